// ===== sv/gpu_mnemonic_classifier_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the mnemonic classifier
// Shared property forms for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef GPU_MNEMONIC_CLASSIFIER_UNIT_ASSERT_SVH
`define GPU_MNEMONIC_CLASSIFIER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Mnemonic classifier package
// Types, character and pattern constants, and the class decision function.
// ----------------------------------------------------------------------------
package gmc_pkg;

    localparam int PREFIX_DEPTH = 9;
    localparam int RECENT_DEPTH = 5;
    localparam logic [3:0] LEN_SAT = 4'd10;

    typedef logic [7:0] t_char;
    typedef logic [3:0] t_len;
    typedef logic [PREFIX_DEPTH-1:0][7:0] t_prefix;
    typedef logic [PREFIX_DEPTH*8-1:0] t_pat;

    typedef enum logic [3:0] {
        CLS_VALU       = 4'd0,
        CLS_SALU       = 4'd1,
        CLS_VMEM_LOAD  = 4'd2,
        CLS_VMEM_STORE = 4'd3,
        CLS_SMEM_LOAD  = 4'd4,
        CLS_SMEM_STORE = 4'd5,
        CLS_LDS        = 4'd6,
        CLS_BRANCH     = 4'd7,
        CLS_WAITCNT    = 4'd8,
        CLS_SENDMSG    = 4'd9,
        CLS_BARRIER    = 4'd10,
        CLS_EXPORT     = 4'd11,
        CLS_MATRIX     = 4'd12,
        CLS_OTHER      = 4'd13
    } t_insn_class;

    // Length and substring flags as they stand after the current item.
    typedef struct packed {
        t_len len;
        logic saw_load;
        logic saw_store;
    } t_win_state;

    localparam t_char CH_US = 8'h5f;
    localparam t_char CH_L  = 8'h6c;
    localparam t_char CH_O  = 8'h6f;
    localparam t_char CH_A  = 8'h61;
    localparam t_char CH_D  = 8'h64;
    localparam t_char CH_S  = 8'h73;
    localparam t_char CH_T  = 8'h74;
    localparam t_char CH_R  = 8'h72;
    localparam t_char CH_E  = 8'h65;

    // Patterns are left-justified: the first character sits in the top byte.
    localparam t_pat PAT_V_WMMA    = {"v_wmma", 24'd0};
    localparam t_pat PAT_V_MFMA    = {"v_mfma", 24'd0};
    localparam t_pat PAT_V         = {"v_", 56'd0};
    localparam t_pat PAT_S         = {"s_", 56'd0};
    localparam t_pat PAT_S_LOAD    = {"s_load", 24'd0};
    localparam t_pat PAT_S_STORE   = {"s_store", 16'd0};
    localparam t_pat PAT_SBRANCH   = {"s_", "branch", 8'd0};
    localparam t_pat PAT_SCBRANCH  = {"s_", "cbranch"};
    localparam t_pat PAT_SWAITCNT  = {"s_", "waitcnt"};
    localparam t_pat PAT_SBARRIER  = {"s_", "barrier"};
    localparam t_pat PAT_SSENDMSG  = {"s_", "sendmsg"};
    localparam t_pat PAT_SENDPGM   = {"s_", "endpgm", 8'd0};
    localparam t_pat PAT_DS        = {"ds_", 48'd0};
    localparam t_pat PAT_BUFFER    = {"buffer_", 16'd0};
    localparam t_pat PAT_GLOBAL    = {"global_", 16'd0};
    localparam t_pat PAT_FLAT      = {"flat_", 32'd0};
    localparam t_pat PAT_EXP_SP    = {"exp ", 40'd0};
    localparam t_pat PAT_EXP       = {"exp", 48'd0};

    function automatic logic starts_with(t_prefix p, t_len len, t_pat pat, t_len n);
        logic ok;
        ok = (len >= n);
        for (int i = 0; i < PREFIX_DEPTH; i++) begin
            if ((4'(i) < n) && (p[i] != pat[(PREFIX_DEPTH-1-i)*8 +: 8])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic equals(t_prefix p, t_len len, t_pat pat, t_len n);
        return (len == n) && starts_with(p, len, pat, n);
    endfunction

    function automatic t_insn_class classify(t_prefix p, t_win_state w);
        t_insn_class cls;
        cls = CLS_OTHER;
        if (w.len == 4'd0) begin
            cls = CLS_OTHER;
        end else if (starts_with(p, w.len, PAT_V_WMMA, 4'd6) ||
                     starts_with(p, w.len, PAT_V_MFMA, 4'd6)) begin
            cls = CLS_MATRIX;
        end else if (starts_with(p, w.len, PAT_V, 4'd2)) begin
            if (w.saw_load) begin
                cls = CLS_VMEM_LOAD;
            end else if (w.saw_store) begin
                cls = CLS_VMEM_STORE;
            end else begin
                cls = CLS_VALU;
            end
        end else if (starts_with(p, w.len, PAT_S, 4'd2)) begin
            if (starts_with(p, w.len, PAT_S_LOAD, 4'd6)) begin
                cls = CLS_SMEM_LOAD;
            end else if (starts_with(p, w.len, PAT_S_STORE, 4'd7)) begin
                cls = CLS_SMEM_STORE;
            end else if (starts_with(p, w.len, PAT_SBRANCH, 4'd8) ||
                         starts_with(p, w.len, PAT_SCBRANCH, 4'd9)) begin
                cls = CLS_BRANCH;
            end else if (starts_with(p, w.len, PAT_SWAITCNT, 4'd9)) begin
                cls = CLS_WAITCNT;
            end else if (equals(p, w.len, PAT_SBARRIER, 4'd9)) begin
                cls = CLS_BARRIER;
            end else if (starts_with(p, w.len, PAT_SSENDMSG, 4'd9)) begin
                cls = CLS_SENDMSG;
            end else if (equals(p, w.len, PAT_SENDPGM, 4'd8)) begin
                cls = CLS_OTHER;
            end else begin
                cls = CLS_SALU;
            end
        end else if (starts_with(p, w.len, PAT_DS, 4'd3)) begin
            cls = CLS_LDS;
        end else if (starts_with(p, w.len, PAT_BUFFER, 4'd7) ||
                     starts_with(p, w.len, PAT_GLOBAL, 4'd7) ||
                     starts_with(p, w.len, PAT_FLAT, 4'd5)) begin
            if (!w.saw_load && w.saw_store) begin
                cls = CLS_VMEM_STORE;
            end else begin
                cls = CLS_VMEM_LOAD;
            end
        end else if (starts_with(p, w.len, PAT_EXP_SP, 4'd4) ||
                     equals(p, w.len, PAT_EXP, 4'd3)) begin
            cls = CLS_EXPORT;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

endpackage

// ===== sv/gmc_char_if.sv =====
// ----------------------------------------------------------------------------
// Character stream interface
// Carries one mnemonic character per item with its end markers.
// ----------------------------------------------------------------------------
interface gmc_char_if;
    import gmc_pkg::*;

    logic  valid;
    logic  ready;
    t_char char_code;
    logic  has_char;
    logic  last;

    modport source (output valid, output char_code, output has_char, output last,
                    input ready);
    modport sink   (input valid, input char_code, input has_char, input last,
                    output ready);
endinterface

// ===== sv/gmc_class_if.sv =====
// ----------------------------------------------------------------------------
// Class result interface
// Carries one instruction class code per item.
// ----------------------------------------------------------------------------
interface gmc_class_if;
    import gmc_pkg::*;

    logic        valid;
    logic        ready;
    t_insn_class insn_class;

    modport source (output valid, output insn_class, input ready);
    modport sink   (input valid, input insn_class, output ready);
endinterface

// ===== sv/gpu_mnemonic_classifier_unit.sv =====
// The class of a mnemonic is registered and valid in the cycle after its ending item.
// One character item is taken per cycle; the prefix cells, the window and
// the class decision all settle within the cycle that takes the item.
// A waiting result stalls input only while the sink holds ready low.
// Reset: synchronous, active low; clears the cell fill flags, length, flags
// and output valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
// GPU mnemonic classifier
// Streams mnemonic characters through a row of prefix cells and a recent
// window, and registers a class code when the mnemonic ends.
// ----------------------------------------------------------------------------
module gpu_mnemonic_classifier_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gmc_char_if.sink     i_char,
    gmc_class_if.source  o_class
);
    import gmc_pkg::*;

    `include "gpu_mnemonic_classifier_unit_assert.svh"

    logic                    w_accept;
    logic                    w_take;
    logic                    w_fin;
    logic [PREFIX_DEPTH-1:0] w_full;
    t_prefix                 w_pfx;
    t_win_state              w_win;
    logic                    r_ov;
    t_insn_class             r_class;

    assign i_char.ready = !r_ov || o_class.ready;
    assign w_accept     = i_char.valid && i_char.ready;
    assign w_take       = w_accept && i_char.has_char;
    assign w_fin        = w_accept && (!i_char.has_char || i_char.last);

    for (genvar g = 0; g < PREFIX_DEPTH; g++) begin : g_cell
        gmc_prefix_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_take      (w_take),
            .i_clr       (w_fin),
            .i_prev_full ((g == 0) ? 1'b1 : w_full[(g == 0) ? 0 : g-1]),
            .i_char      (i_char.char_code),
            .o_full      (w_full[g]),
            .o_char_nxt  (w_pfx[g])
        );
    end

    gmc_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_clr   (w_fin),
        .i_char  (i_char.char_code),
        .o_nxt   (w_win)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_fin) begin
            r_ov <= 1'b1;
        end else if (o_class.ready) begin
            r_ov <= 1'b0;
        end
        if (w_fin) begin
            r_class <= classify(w_pfx, w_win);
        end
    end

    assign o_class.valid      = r_ov;
    assign o_class.insn_class = r_class;

    `GMC_ASSERT_NEXT(a_fin_result, i_clk, i_rst_n, w_fin, o_class.valid, "missing result")
    `GMC_ASSERT_NEXT(a_fin_clear, i_clk, i_rst_n, w_fin, w_full == '0, "cells not cleared")
    `GMC_ASSERT_NEXT(a_take_fill, i_clk, i_rst_n, w_take && !w_fin, w_full[0], "cell 0 empty")
    `GMC_ASSERT_NOW(a_order, i_clk, i_rst_n, w_full[PREFIX_DEPTH-1], w_full[0], "fill order")
endmodule

// ===== sv/gmc_prefix_cell.sv =====
// ----------------------------------------------------------------------------
// Prefix cell
// Holds one character of the mnemonic prefix. A fill token runs down the row:
// a cell captures the next character once its left neighbor is full.
// ----------------------------------------------------------------------------
module gmc_prefix_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic           i_clr,
    input  logic           i_prev_full,
    input  gmc_pkg::t_char i_char,
    output logic           o_full,
    output gmc_pkg::t_char o_char_nxt
);
    import gmc_pkg::*;

    logic  r_full;
    logic  n_full;
    t_char r_char;
    t_char n_char;
    logic  w_wr;

    assign w_wr   = i_take && i_prev_full && !r_full;
    assign n_char = w_wr ? i_char : r_char;
    assign n_full = r_full || w_wr;

    // A cell is only read once it is full, so the character needs no clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_clr) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
        r_char <= n_char;
    end

    assign o_full     = r_full;
    assign o_char_nxt = n_char;
endmodule

// ===== sv/gmc_window.sv =====
// ----------------------------------------------------------------------------
// Recent-character window
// A five-tap shift line of the newest characters, the saturating length count
// and the sticky substring flags for "_load" and "_store".
// ----------------------------------------------------------------------------
module gmc_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic               i_clr,
    input  gmc_pkg::t_char     i_char,
    output gmc_pkg::t_win_state o_nxt
);
    import gmc_pkg::*;

    t_char      r_rc [RECENT_DEPTH];
    t_win_state r_st;
    t_win_state n_st;
    logic       w_load_hit;
    logic       w_store_hit;

    assign w_load_hit = (r_rc[1] == CH_US) && (r_rc[2] == CH_L) && (r_rc[3] == CH_O) &&
                        (r_rc[4] == CH_A) && (i_char == CH_D) && (r_st.len >= 4'd4);
    assign w_store_hit = (r_rc[0] == CH_US) && (r_rc[1] == CH_S) && (r_rc[2] == CH_T) &&
                         (r_rc[3] == CH_O) && (r_rc[4] == CH_R) && (i_char == CH_E) &&
                         (r_st.len >= 4'd5);

    always_comb begin
        n_st = r_st;
        if (i_take) begin
            if (r_st.len < LEN_SAT) begin
                n_st.len = r_st.len + 4'd1;
            end
            n_st.saw_load  = r_st.saw_load || w_load_hit;
            n_st.saw_store = r_st.saw_store || w_store_hit;
        end
    end

    // The length guards on the hits keep stale taps from a previous mnemonic
    // out of the match, so the taps are never cleared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_clr) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
        if (i_take) begin
            for (int i = 0; i < RECENT_DEPTH - 1; i++) begin
                r_rc[i] <= r_rc[i+1];
            end
            r_rc[RECENT_DEPTH-1] <= i_char;
        end
    end

    assign o_nxt = n_st;
endmodule
